@@ hdl/three_level_priority_queue_aging_top_assert.svh @@
// Assertion macros for the three-level priority queue.
// Define NO_ASSERTIONS to drop every check.
`ifndef THREE_LEVEL_PRIORITY_QUEUE_AGING_TOP_ASSERT_SVH
`define THREE_LEVEL_PRIORITY_QUEUE_AGING_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising clock edge out of reset.
`define TLPQ_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tlpq check failed: same-cycle implication");

// Next-cycle implication.
`define TLPQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tlpq check failed: next-cycle implication");

`else

`define TLPQ_ASSERT_SAME(label, ante, cons)
`define TLPQ_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ hdl/tlpq_pkg.sv @@
`timescale 1ns / 1ps

package tlpq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int ID_BITS     = 8;
   localparam int NUM_LEVELS  = 3;
   localparam int MEM_DEPTH   = NUM_LEVELS * QUEUE_DEPTH;
   localparam int PTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_BITS   = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_BITS   = $clog2(MEM_DEPTH);
   localparam int WAIT_BITS   = 4;
   localparam int WAIT_MAX    = 15;

   typedef logic [ID_BITS-1:0]   id_type;
   typedef logic [1:0]           level_type;
   typedef logic [PTR_BITS-1:0]  ptr_type;
   typedef logic [FILL_BITS-1:0] fill_type;
   typedef logic [ADDR_BITS-1:0] addr_type;
   typedef logic [WAIT_BITS-1:0] wait_type;

   typedef enum logic [1:0] {
      KIND_ENQ = 2'd0,
      KIND_DEQ = 2'd1,
      KIND_AGE = 2'd2,
      KIND_NOP = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_DROP  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic     en;
      addr_type addr;
      id_type   data;
   } wr_type;

   function automatic addr_type mem_addr(input level_type lvl, input ptr_type ptr);
      return addr_type'(int'(lvl) * QUEUE_DEPTH + int'(ptr));
   endfunction

   function automatic ptr_type ptr_next(input ptr_type ptr);
      if (ptr == ptr_type'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + 1'b1;
   endfunction

   function automatic wait_type wait_bump(input wait_type cnt, input logic busy);
      if (!busy) begin
         return '0;
      end
      if (cnt == wait_type'(WAIT_MAX)) begin
         return cnt;
      end
      return cnt + 1'b1;
   endfunction

endpackage

@@ hdl/tlpq_store.sv @@
`timescale 1ns / 1ps

module tlpq_store (
   input  logic              clock,
   input  tlpq_pkg::wr_type  wr,
   input  logic              rd_en,
   input  tlpq_pkg::addr_type rd_a_addr,
   input  tlpq_pkg::addr_type rd_b_addr,
   output tlpq_pkg::id_type  rd_a_data,
   output tlpq_pkg::id_type  rd_b_data
);
   import tlpq_pkg::*;

   id_type mem [MEM_DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // hold read data between reads so a request that waits to execute keeps its ids
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_data <= mem[rd_a_addr];
         rd_b_data <= mem[rd_b_addr];
      end
   end

endmodule

@@ hdl/three_level_priority_queue_aging_top.sv @@
`timescale 1ns / 1ps

// Three-level strict priority queue of item ids with aging of waiting heads.
// Request channel (req_*): one transfer carries kind (enqueue, dequeue, aging
// check), item_id and level. It is taken when req_valid is high and req_stall
// is low. Response channel (rsp_*): exactly one result per request, in order,
// with status, served_id, served_level and promoted.
// Configuration: csr_wr_en writes aging_limit (4 bits, reset 3); write it only
// while no request is in flight.
// Flow: a taken request is latched together with its registered memory read,
// then executes once the output register is free, and its result is
// registered there. No new request is taken until it is done; an aging
// check that moves heads on both levels also passes the flush state, since
// the queue memory has a single write port and writes the second move there.
// Reset clears all pointers, fill counts, waiting counters and the response
// valid; queue contents are left as they are and never read before written.
// When the receiver stalls, the result holds in the output register; one more
// request may be taken and then waits until the result leaves.
module three_level_priority_queue_aging_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_kind,
   input  tlpq_pkg::id_type      req_item_id,
   input  tlpq_pkg::level_type   req_level,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_status,
   output tlpq_pkg::id_type      rsp_served_id,
   output tlpq_pkg::level_type   rsp_served_level,
   output logic [1:0]            rsp_promoted,
   input  logic                  csr_wr_en,
   input  logic [3:0]            csr_wr_data
);
   import tlpq_pkg::*;

`include "three_level_priority_queue_aging_top_assert.svh"

   state_type  state_ff, state_in;

   // latched request
   kind_type   kind_ff;
   id_type     id_ff;
   level_type  level_ff;

   // queue bookkeeping
   ptr_type    head_ff [NUM_LEVELS];
   ptr_type    head_in [NUM_LEVELS];
   ptr_type    tail_ff [NUM_LEVELS];
   ptr_type    tail_in [NUM_LEVELS];
   fill_type   fill_ff [NUM_LEVELS];
   fill_type   fill_in [NUM_LEVELS];
   wait_type   wait_ff [2];
   wait_type   wait_in [2];
   wait_type   limit_ff;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   id_type     rsp_id_ff, rsp_id_in;
   level_type  rsp_level_ff, rsp_level_in;
   logic [1:0] rsp_promoted_ff, rsp_promoted_in;

   // second write of a double promotion
   addr_type   pend_addr_ff, pend_addr_in;
   id_type     pend_data_ff, pend_data_in;

   logic       req_accept;
   logic       exec_go;
   level_type  deq_level;
   logic       deq_none;
   addr_type   rd_a_addr, rd_b_addr;
   id_type     rd_a_data, rd_b_data;
   wr_type     wr;

   // aging decisions
   logic       fire2, fire1, mv2, mv1;
   fill_type   fill1_mid;
   id_type     age_id1;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign exec_go    = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_served_id    = rsp_id_ff;
   assign rsp_served_level = rsp_level_ff;
   assign rsp_promoted     = rsp_promoted_ff;

   // highest non-empty level; state does not move between accept and execute
   always_comb begin
      deq_none  = 1'b0;
      deq_level = 2'd0;
      if (fill_ff[0] != '0) begin
         deq_level = 2'd0;
      end else if (fill_ff[1] != '0) begin
         deq_level = 2'd1;
      end else if (fill_ff[2] != '0) begin
         deq_level = 2'd2;
      end else begin
         deq_none = 1'b1;
      end
   end

   // port A: dequeue head or level 2 head; port B: level 1 head
   always_comb begin
      if (kind_type'(req_kind) == KIND_DEQ) begin
         rd_a_addr = mem_addr(deq_level, head_ff[deq_level]);
      end else begin
         rd_a_addr = mem_addr(2'd2, head_ff[2]);
      end
      rd_b_addr = mem_addr(2'd1, head_ff[1]);
   end

   tlpq_store u_store (
      .clock     (clock),
      .wr        (wr),
      .rd_en     (req_accept),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   // aging: level 2 to 1 first, then level 1 to 0 on the updated fill
   always_comb begin
      fire2     = (wait_ff[1] >= limit_ff);
      mv2       = fire2 && (fill_ff[2] != '0) && (fill_ff[1] != fill_type'(QUEUE_DEPTH));
      fill1_mid = fill_ff[1] + fill_type'(mv2);
      fire1     = (wait_ff[0] >= limit_ff);
      mv1       = fire1 && (fill1_mid != '0) && (fill_ff[0] != fill_type'(QUEUE_DEPTH));
      // an empty level 1 gets its head from the item just moved up
      age_id1   = (fill_ff[1] == '0) ? rd_a_data : rd_b_data;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_go) begin
               if (kind_ff == KIND_AGE && mv2 && mv1) begin
                  state_in = ST_FLUSH;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FLUSH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // execute: queue updates, memory write and result
   always_comb begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
         head_in[i] = head_ff[i];
         tail_in[i] = tail_ff[i];
         fill_in[i] = fill_ff[i];
      end
      wait_in[0]      = wait_ff[0];
      wait_in[1]      = wait_ff[1];
      wr              = '0;
      pend_addr_in    = pend_addr_ff;
      pend_data_in    = pend_data_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_status_in   = rsp_status_ff;
      rsp_id_in       = rsp_id_ff;
      rsp_level_in    = rsp_level_ff;
      rsp_promoted_in = rsp_promoted_ff;

      case (state_ff)
         ST_EXEC: begin
            if (exec_go) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = STATUS_OK;
               rsp_id_in       = '0;
               rsp_level_in    = '0;
               rsp_promoted_in = '0;
               case (kind_ff)
                  KIND_ENQ: begin
                     if (level_ff inside {2'd0, 2'd1, 2'd2}) begin
                        if (fill_ff[level_ff] == fill_type'(QUEUE_DEPTH)) begin
                           rsp_status_in = STATUS_DROP;
                        end else begin
                           wr.en             = 1'b1;
                           wr.addr           = mem_addr(level_ff, tail_ff[level_ff]);
                           wr.data           = id_ff;
                           tail_in[level_ff] = ptr_next(tail_ff[level_ff]);
                           fill_in[level_ff] = fill_ff[level_ff] + 1'b1;
                        end
                     end else begin
                        rsp_status_in = STATUS_DROP;
                     end
                  end
                  KIND_DEQ: begin
                     if (deq_none) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        // advance the waiting counters of bypassed non-empty levels, clear empty ones
                        if (deq_level == 2'd0) begin
                           wait_in[0] = wait_bump(wait_ff[0], fill_ff[1] != '0);
                           wait_in[1] = wait_bump(wait_ff[1], fill_ff[2] != '0);
                        end else if (deq_level == 2'd1) begin
                           wait_in[1] = wait_bump(wait_ff[1], fill_ff[2] != '0);
                        end
                        head_in[deq_level] = ptr_next(head_ff[deq_level]);
                        fill_in[deq_level] = fill_ff[deq_level] - 1'b1;
                        rsp_id_in          = rd_a_data;
                        rsp_level_in       = deq_level;
                     end
                  end
                  KIND_AGE: begin
                     if (fire2) begin
                        wait_in[1] = '0;
                     end
                     if (fire1) begin
                        wait_in[0] = '0;
                     end
                     if (mv2) begin
                        wr.en      = 1'b1;
                        wr.addr    = mem_addr(2'd1, tail_ff[1]);
                        wr.data    = rd_a_data;
                        head_in[2] = ptr_next(head_ff[2]);
                        fill_in[2] = fill_ff[2] - 1'b1;
                        tail_in[1] = ptr_next(tail_ff[1]);
                     end
                     if (mv1) begin
                        if (mv2) begin
                           // defer: memory takes one write per cycle
                           pend_addr_in = mem_addr(2'd0, tail_ff[0]);
                           pend_data_in = age_id1;
                        end else begin
                           wr.en   = 1'b1;
                           wr.addr = mem_addr(2'd0, tail_ff[0]);
                           wr.data = age_id1;
                        end
                        head_in[1] = ptr_next(head_ff[1]);
                        tail_in[0] = ptr_next(tail_ff[0]);
                        fill_in[0] = fill_ff[0] + 1'b1;
                     end
                     fill_in[1]      = fill1_mid - fill_type'(mv1);
                     rsp_promoted_in = {mv1, mv2};
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FLUSH: begin
            wr.en   = 1'b1;
            wr.addr = pend_addr_ff;
            wr.data = pend_data_ff;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= wait_type'(3);
         wait_ff[0]   <= '0;
         wait_ff[1]   <= '0;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         wait_ff[0] <= wait_in[0];
         wait_ff[1] <= wait_in[1];
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i] <= head_in[i];
            tail_ff[i] <= tail_in[i];
            fill_ff[i] <= fill_in[i];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff  <= kind_type'(req_kind);
         id_ff    <= req_item_id;
         level_ff <= req_level;
      end
      rsp_status_ff   <= rsp_status_in;
      rsp_id_ff       <= rsp_id_in;
      rsp_level_ff    <= rsp_level_in;
      rsp_promoted_ff <= rsp_promoted_in;
      pend_addr_ff    <= pend_addr_in;
      pend_data_ff    <= pend_data_in;
   end

   // checks
   `TLPQ_ASSERT_SAME(a_fill_bound, 1'b1, (fill_ff[0] <= fill_type'(QUEUE_DEPTH)) && (fill_ff[1] <= fill_type'(QUEUE_DEPTH)) && (fill_ff[2] <= fill_type'(QUEUE_DEPTH)))
   `TLPQ_ASSERT_SAME(a_flush_has_result, state_ff == ST_FLUSH, rsp_valid_ff)
   `TLPQ_ASSERT_NEXT(a_accept_to_exec, req_accept, state_ff == ST_EXEC)

endmodule
